// ----- sv/rqp_pkg.sv -----
// Shared types and constants of the ring queue pair pointer engine.
// No dependencies; every other file of the block imports this package.
package rqp_pkg;

  localparam int MIN_RING_LOG2 = 12;
  localparam int LOG2_W        = 5;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 5;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SEND_RING_LOG2 = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RECV_RING_LOG2 = 1'd1;

  typedef enum logic [2:0] {
    OP_SEND_BEGIN  = 3'd0,
    OP_SEND_APPEND = 3'd1,
    OP_SEND_SKIP   = 3'd2,
    OP_SEND_COMMIT = 3'd3,
    OP_RECV_BEGIN  = 3'd4,
    OP_RECV_TAKE   = 3'd5,
    OP_RECV_COMMIT = 3'd6
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK                 = 2'd0,
    ST_RESOURCE_EXHAUSTED = 2'd1,
    ST_UNAVAILABLE        = 2'd2,
    ST_OUT_OF_RANGE       = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] byte_count;
    logic [63:0] doorbell_value;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [23:0] first_offset;
    logic [24:0] first_length;
    logic [23:0] second_offset;
    logic [24:0] second_length;
    logic [24:0] window_bytes;
    logic        doorbell_write_valid;
    logic [63:0] doorbell_write_value;
  } rsp_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic diff_en;
    logic step_en;
  } ctrl_t;

endpackage

// ----- sv/rqp_ctrl.sv -----
// Controller of the ring queue pair pointer engine: sequences each command
// through capture, counter difference and window update. Uses rqp_pkg.
module rqp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output rqp_pkg::ctrl_t ctrl
);
  import rqp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIFF = 3'b010,
    S_STEP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DIFF;
      end
      S_DIFF: state_next = S_STEP;
      S_STEP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_STEP);
    end
  end

  assign busy         = (state != S_IDLE);
  assign ctrl.load    = (state == S_IDLE) && start;
  assign ctrl.diff_en = (state == S_DIFF);
  assign ctrl.step_en = (state == S_STEP);

endmodule

// ----- sv/rqp_datapath.sv -----
// Datapath of the ring queue pair pointer engine: ring size registers,
// byte counters, open send/receive windows and the result register. Uses rqp_pkg.
module rqp_datapath #(
  parameter int MAX_RING_LOG2 = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rqp_pkg::ctrl_t                        ctrl,
  input  rqp_pkg::cmd_t                         command,
  input  logic                                  cfg_we,
  input  logic [rqp_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [rqp_pkg::CFG_DATA_W-1:0]        cfg_data,
  output rqp_pkg::rsp_t                         result
);
  import rqp_pkg::*;

  localparam int LW = MAX_RING_LOG2 + 1;  // lengths, up to a full ring
  localparam int OW = MAX_RING_LOG2;      // ring offsets

  // configuration and architectural state
  logic [LOG2_W-1:0] send_lg;
  logic [LOG2_W-1:0] recv_lg;
  logic [63:0]       produced;
  logic [63:0]       consumed;
  logic [OW-1:0]     s_off;
  logic [LW-1:0]     s_len;
  logic [LW-1:0]     s_wrap;
  logic [LW-1:0]     s_pend;
  logic [OW-1:0]     r_off;
  logic [LW-1:0]     r_len;
  logic [LW-1:0]     r_wrap;
  logic [LW-1:0]     r_taken;

  logic [63:0]       produced_next;
  logic [63:0]       consumed_next;
  logic [OW-1:0]     s_off_next;
  logic [LW-1:0]     s_len_next;
  logic [LW-1:0]     s_wrap_next;
  logic [LW-1:0]     s_pend_next;
  logic [OW-1:0]     r_off_next;
  logic [LW-1:0]     r_len_next;
  logic [LW-1:0]     r_wrap_next;
  logic [LW-1:0]     r_taken_next;

  // command word and counter difference
  cmd_t              cmd_q;
  logic [63:0]       diff;
  rsp_t              rsp_next;

  // ring geometry
  logic [5:0]        s_lg_eff;
  logic [5:0]        r_lg_eff;
  logic [LW-1:0]     ssize;
  logic [LW-1:0]     rsize;
  logic [OW-1:0]     smask;
  logic [OW-1:0]     rmask;

  always_comb begin
    priority if (send_lg < LOG2_W'(MIN_RING_LOG2)) s_lg_eff = 6'(MIN_RING_LOG2);
    else if (6'(send_lg) > 6'(MAX_RING_LOG2))      s_lg_eff = 6'(MAX_RING_LOG2);
    else                                           s_lg_eff = 6'(send_lg);
    priority if (recv_lg < LOG2_W'(MIN_RING_LOG2)) r_lg_eff = 6'(MIN_RING_LOG2);
    else if (6'(recv_lg) > 6'(MAX_RING_LOG2))      r_lg_eff = 6'(MAX_RING_LOG2);
    else                                           r_lg_eff = 6'(recv_lg);
  end

  assign ssize = LW'(1) << s_lg_eff;
  assign rsize = LW'(1) << r_lg_eff;
  assign smask = OW'(ssize - LW'(1));
  assign rmask = OW'(rsize - LW'(1));

  // difference checks
  logic          diff_hi;
  logic [LW-1:0] diff_lo;
  logic          over_s;
  logic          over_r;
  logic [63:0]   n64;

  assign diff_hi = |diff[63:LW];
  assign diff_lo = diff[LW-1:0];
  assign over_s  = diff_hi || (diff_lo > ssize);
  assign over_r  = diff_hi || (diff_lo > rsize);
  assign n64     = 64'(cmd_q.byte_count);

  // send_begin window
  logic [LW-1:0] sb_free;
  logic [OW-1:0] sb_off;
  logic [LW-1:0] sb_room;
  logic [LW-1:0] sb_first;

  assign sb_free  = ssize - diff_lo;
  assign sb_off   = produced[OW-1:0] & smask;
  assign sb_room  = ssize - LW'(sb_off);
  assign sb_first = (sb_free > sb_room) ? sb_room : sb_free;

  // recv_begin window
  logic [OW-1:0] rb_start;
  logic [LW-1:0] rb_room;
  logic [LW-1:0] rb_first;

  assign rb_start = consumed[OW-1:0] & rmask;
  assign rb_room  = rsize - LW'(rb_start);
  assign rb_first = (diff_lo < rb_room) ? diff_lo : rb_room;

  // send append / skip
  logic [LW:0]   s_total;
  logic          s_short;
  logic [LW-1:0] sa_len1;
  logic [LW-1:0] sa_len2;
  logic [OW-1:0] sa_off_adv;

  assign s_total    = (LW+1)'(s_len) + (LW+1)'(s_wrap);
  assign s_short    = 64'(s_total) < n64;
  assign sa_len1    = (n64 < 64'(s_len)) ? LW'(cmd_q.byte_count) : s_len;
  assign sa_len2    = LW'(n64 - 64'(sa_len1));
  assign sa_off_adv = OW'(LW'(s_off) + sa_len1) & smask;

  // recv take
  logic [LW:0]   r_total;
  logic          r_short;
  logic [LW-1:0] rt_t1;
  logic [LW-1:0] rt_t2;
  logic [LW-1:0] rt_rem;
  logic [OW-1:0] rt_off_adv;

  assign r_total    = (LW+1)'(r_len) + (LW+1)'(r_wrap);
  assign r_short    = 64'(r_total) < n64;
  assign rt_t1      = (n64 < 64'(r_len)) ? LW'(cmd_q.byte_count) : r_len;
  assign rt_t2      = LW'(n64 - 64'(rt_t1));
  assign rt_rem     = r_len - rt_t1;
  assign rt_off_adv = OW'(LW'(r_off) + rt_t1) & rmask;

  always_comb begin
    produced_next = produced;
    consumed_next = consumed;
    s_off_next    = s_off;
    s_len_next    = s_len;
    s_wrap_next   = s_wrap;
    s_pend_next   = s_pend;
    r_off_next    = r_off;
    r_len_next    = r_len;
    r_wrap_next   = r_wrap;
    r_taken_next  = r_taken;
    rsp_next      = '0;
    unique case (cmd_q.opcode)
      OP_SEND_BEGIN: begin
        s_off_next  = '0;
        s_len_next  = '0;
        s_wrap_next = '0;
        s_pend_next = '0;
        if (over_s) begin
          rsp_next.status = ST_OUT_OF_RANGE;
        end else begin
          s_off_next             = sb_off;
          s_len_next             = sb_first;
          s_wrap_next            = sb_free - sb_first;
          rsp_next.first_offset  = 24'(sb_off);
          rsp_next.first_length  = 25'(sb_first);
          rsp_next.second_length = 25'(sb_free - sb_first);
          rsp_next.window_bytes  = 25'(sb_free);
        end
      end
      OP_SEND_APPEND, OP_SEND_SKIP: begin
        if (s_short) begin
          rsp_next.status = ST_RESOURCE_EXHAUSTED;
        end else begin
          // spill into the wrap part restarts near ring offset zero
          if (sa_len2 != '0) begin
            s_off_next  = OW'(sa_len2) & smask;
            s_len_next  = s_wrap - sa_len2;
            s_wrap_next = '0;
          end else begin
            s_off_next = sa_off_adv;
            s_len_next = s_len - sa_len1;
          end
          s_pend_next = s_pend + LW'(cmd_q.byte_count);
          if (cmd_q.opcode == OP_SEND_APPEND) begin
            rsp_next.first_offset  = (sa_len1 != '0) ? 24'(s_off) : '0;
            rsp_next.first_length  = 25'(sa_len1);
            rsp_next.second_length = 25'(sa_len2);
          end
        end
      end
      OP_SEND_COMMIT: begin
        produced_next                 = produced + 64'(s_pend);
        s_off_next                    = '0;
        s_len_next                    = '0;
        s_wrap_next                   = '0;
        s_pend_next                   = '0;
        rsp_next.doorbell_write_valid = 1'b1;
        rsp_next.doorbell_write_value = produced + 64'(s_pend);
      end
      OP_RECV_BEGIN: begin
        priority if (diff == '0) begin
          rsp_next.status = ST_UNAVAILABLE;
        end else if (over_r) begin
          rsp_next.status = ST_OUT_OF_RANGE;
        end else begin
          r_off_next             = rb_start;
          r_len_next             = rb_first;
          r_wrap_next            = diff_lo - rb_first;
          r_taken_next           = '0;
          rsp_next.first_offset  = 24'(rb_start);
          rsp_next.first_length  = 25'(rb_first);
          rsp_next.second_length = 25'(diff_lo - rb_first);
          rsp_next.window_bytes  = 25'(diff_lo);
        end
      end
      OP_RECV_TAKE: begin
        if (r_short) begin
          rsp_next.status = ST_UNAVAILABLE;
        end else begin
          // an exhausted first part hands over to the wrap part at offset zero
          if (rt_rem == '0) begin
            r_off_next  = OW'(rt_t2) & rmask;
            r_len_next  = r_wrap - rt_t2;
            r_wrap_next = '0;
          end else begin
            r_off_next = rt_off_adv;
            r_len_next = rt_rem;
          end
          r_taken_next           = r_taken + LW'(cmd_q.byte_count);
          rsp_next.first_offset  = (rt_t1 != '0) ? 24'(r_off) : '0;
          rsp_next.first_length  = 25'(rt_t1);
          rsp_next.second_length = 25'(rt_t2);
        end
      end
      OP_RECV_COMMIT: begin
        consumed_next                 = consumed + 64'(r_taken);
        r_off_next                    = '0;
        r_len_next                    = '0;
        r_wrap_next                   = '0;
        r_taken_next                  = '0;
        rsp_next.doorbell_write_valid = 1'b1;
        rsp_next.doorbell_write_value = consumed + 64'(r_taken);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_lg  <= LOG2_W'(MIN_RING_LOG2);
      recv_lg  <= LOG2_W'(MIN_RING_LOG2);
      produced <= '0;
      consumed <= '0;
      s_off    <= '0;
      s_len    <= '0;
      s_wrap   <= '0;
      s_pend   <= '0;
      r_off    <= '0;
      r_len    <= '0;
      r_wrap   <= '0;
      r_taken  <= '0;
    end else if (cfg_we) begin
      // a new ring size drops that ring's open batch
      if (cfg_index == REG_SEND_RING_LOG2) begin
        send_lg <= cfg_data;
        s_off   <= '0;
        s_len   <= '0;
        s_wrap  <= '0;
        s_pend  <= '0;
      end
      if (cfg_index == REG_RECV_RING_LOG2) begin
        recv_lg <= cfg_data;
        r_off   <= '0;
        r_len   <= '0;
        r_wrap  <= '0;
        r_taken <= '0;
      end
    end else if (ctrl.step_en) begin
      produced <= produced_next;
      consumed <= consumed_next;
      s_off    <= s_off_next;
      s_len    <= s_len_next;
      s_wrap   <= s_wrap_next;
      s_pend   <= s_pend_next;
      r_off    <= r_off_next;
      r_len    <= r_len_next;
      r_wrap   <= r_wrap_next;
      r_taken  <= r_taken_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q <= command;
    end
    if (ctrl.diff_en) begin
      if (cmd_q.opcode == OP_RECV_BEGIN) begin
        diff <= cmd_q.doorbell_value - consumed;
      end else begin
        diff <= produced - cmd_q.doorbell_value;
      end
    end
    if (ctrl.step_en) begin
      result <= rsp_next;
    end
  end

endmodule

// ----- sv/ring_queue_pair_pointer_engine.sv -----
// Top level of the ring queue pair pointer engine: controller plus datapath.
// Depends on rqp_pkg, rqp_ctrl and rqp_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  command  | start, busy          | command (cmd_t: opcode, byte_count, bell)
//  result   | done (one cycle)     | result (rsp_t: status, regions, doorbell)
//  config   | cfg_we               | cfg_index, cfg_data
//
// A command passes from acceptance to its done strobe through capture, the
// 64-bit counter difference, then the window update; one command is in
// flight at a time, so no new word is taken while busy is high.
// Reset is synchronous: ring sizes return to 4 KiB, counters and windows clear.
// The receiver cannot stall; the result word is valid only while done is high.
module ring_queue_pair_pointer_engine #(
  parameter int MAX_RING_LOG2 = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  rqp_pkg::cmd_t                   command,
  output logic                            done,
  output rqp_pkg::rsp_t                   result,
  input  logic                            cfg_we,
  input  logic [rqp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rqp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rqp_pkg::*;

  ctrl_t ctrl;

  rqp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  rqp_datapath #(
    .MAX_RING_LOG2 (MAX_RING_LOG2)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .command   (command),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  a_done_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result strobe did not follow an accepted command");

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a command is still in work");

  a_done_has_cmd : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in work");

endmodule
